// ===== src/pst_pkg.sv =====
// shared types, sizes and codes for the process slot table
package pst_pkg;

    // table geometry
    localparam int SLOTS    = 16;
    localparam int PID_BITS = 16;

    // fixed field widths of the channels
    localparam int ID_W     = 16;
    localparam int HANDLE_W = 32;
    localparam int RCOUNT_W = 5;

    // derived sizes
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (PID_BITS > ID_W) ? PID_BITS : ID_W;
    localparam int OCW   = (CNT_W > RCOUNT_W) ? CNT_W : RCOUNT_W;

    // command codes
    typedef enum logic [1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_BIND    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_COUNT   = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_BOUND   = 3'd3,
        ST_NULL    = 3'd4
    } t_status;

    // input beat
    typedef struct packed {
        t_op                 cmd;
        logic [ID_W-1:0]     target_id;
        logic [HANDLE_W-1:0] space_handle;
    } t_in;

    // output beat
    typedef struct packed {
        t_status             status;
        logic [ID_W-1:0]     new_id;
        logic [RCOUNT_W-1:0] running_count;
    } t_out;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic finish;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic quick;
        logic hit;
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== src/pst_ctrl.sv =====
// controller state machine for the process slot table
module pst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  pst_pkg::t_dp_stat i_stat,
    output pst_pkg::t_dp_cmd  o_cmd
);
    import pst_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.quick || i_stat.hit || i_stat.last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_HOLD;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/pst_dp.sv =====
// slot table storage, scan index, counters and result registers
module pst_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pst_pkg::t_dp_cmd  i_cmd,
    output pst_pkg::t_dp_stat o_stat,
    input  pst_pkg::t_in      i_in_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output pst_pkg::t_out     o_out_data
);
    import pst_pkg::*;

    // latched item and scan index
    t_in                  r_in;
    logic [IDX_W-1:0]     r_idx;

    // slot table
    logic [SLOTS-1:0]     r_valid;
    logic [PID_BITS-1:0]  r_slot_pid [SLOTS];
    logic [SLOTS-1:0]     r_slot_bound;
    logic [HANDLE_W-1:0]  mem_space [SLOTS];

    // counters
    logic [CNT_W-1:0]     r_count;
    logic [PID_BITS-1:0]  r_next_pid;

    // pending result and output beat
    t_status              r_status;
    logic [ID_W-1:0]      r_new_id;
    logic                 r_out_valid;
    t_out                 r_out;

    // combinational helpers
    logic [CMP_W-1:0]     w_in_id;
    logic [CMP_W-1:0]     w_slot_id;
    logic [CMP_W-1:0]     w_next_ext;
    logic [OCW-1:0]       w_cnt_ext;
    logic                 w_hit;
    logic                 w_quick;
    t_status              w_status;
    logic                 w_acq;
    logic                 w_bind;
    logic                 w_rel;

    // slot probe at the scan index
    assign w_in_id    = CMP_W'(r_in.target_id);
    assign w_slot_id  = CMP_W'(r_slot_pid[r_idx]);
    assign w_next_ext = CMP_W'(r_next_pid);
    assign w_cnt_ext  = OCW'(r_count);

    always_comb begin
        if (r_in.cmd == CMD_ACQUIRE) begin
            w_hit = !r_valid[r_idx];
        end else begin
            w_hit = r_valid[r_idx] && (w_in_id == w_slot_id);
        end
    end

    // items answered without a scan
    assign w_quick = (r_in.cmd == CMD_COUNT) ||
                     ((r_in.cmd == CMD_BIND) && (r_in.space_handle == '0));

    // outcome of the item at the end of the scan
    always_comb begin
        w_status = ST_OK;
        w_acq    = 1'b0;
        w_bind   = 1'b0;
        w_rel    = 1'b0;
        unique case (r_in.cmd)
            CMD_ACQUIRE: begin
                if (w_hit) begin
                    w_acq = 1'b1;
                end else begin
                    w_status = ST_FULL;
                end
            end
            CMD_BIND: begin
                priority if (r_in.space_handle == '0) begin
                    w_status = ST_NULL;
                end else if (!w_hit) begin
                    w_status = ST_UNKNOWN;
                end else if (r_slot_bound[r_idx]) begin
                    w_status = ST_BOUND;
                end else begin
                    w_bind = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (w_hit) begin
                    w_rel = 1'b1;
                end else begin
                    w_status = ST_UNKNOWN;
                end
            end
            CMD_COUNT: begin
                w_status = ST_OK;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // control state: valid bits, counters, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_next_pid  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish && w_acq) begin
                r_valid[r_idx] <= 1'b1;
                r_count        <= r_count + CNT_W'(1);
                r_next_pid     <= r_next_pid + PID_BITS'(1);
            end else if (i_cmd.finish && w_rel) begin
                r_valid[r_idx] <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: item capture, scan index, slot fields, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in  <= i_in_data;
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.finish) begin
            r_status <= w_status;
            r_new_id <= w_acq ? w_next_ext[ID_W-1:0] : '0;
            if (w_acq) begin
                r_slot_pid[r_idx]   <= r_next_pid;
                r_slot_bound[r_idx] <= 1'b0;
            end else if (w_bind) begin
                r_slot_bound[r_idx] <= 1'b1;
            end else if (w_rel) begin
                r_slot_bound[r_idx] <= 1'b0;
            end
        end
        if (i_cmd.load_out) begin
            r_out.status        <= r_status;
            r_out.new_id        <= r_new_id;
            r_out.running_count <= w_cnt_ext[RCOUNT_W-1:0];
        end
    end

    // address space handles, written by bind and cleared by acquire
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && w_bind) begin
            mem_space[r_idx] <= r_in.space_handle;
        end else if (i_cmd.finish && w_acq) begin
            mem_space[r_idx] <= '0;
        end
    end

    // status back to the controller
    assign o_stat.quick    = w_quick;
    assign o_stat.hit      = w_hit;
    assign o_stat.last     = (r_idx == IDX_W'(SLOTS - 1));
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/process_slot_table.sv =====
// top level of the process slot table: controller plus datapath
//
//   channel   direction   handshake                  beat
//   in        input       i_in_valid / o_in_stall    pst_pkg::t_in
//   out       output      o_out_valid / i_out_stall  pst_pkg::t_out
//
// one item at a time: acquire, bind and release walk the table one slot per
// cycle until a matching slot or the last slot; count queries and null-handle
// binds are answered without a scan. each result is then loaded into the output
// register once it is free. reset is synchronous and clears the valid bits, the
// counters and the output valid. a stalled output beat does not block the next
// input beat; only the loading of the following result waits for it.
module process_slot_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pst_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pst_pkg::t_out o_out_data
);
    import pst_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    pst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // slot table and result path
    pst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sim/tb_process_slot_table.sv =====
// testbench for the process slot table: directed rows and random traffic
`timescale 1ns / 100ps

module tb_process_slot_table;
    import pst_pkg::*;

    localparam int CLK_HALF         = 2;
    localparam int RESET_CYCLES     = 9;
    localparam int CYCLE_LIMIT      = 5_000_000;
    localparam int RANDOM_PER_PHASE = 340;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 4 * SLOTS;

    // traffic phases of the random part
    typedef enum int {
        PH_FREE,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE,
        PH_BACKPRESSURE,
        PH_COUNT
    } t_phase;

    // one directed row: beat plus an optional hand-written reply
    typedef struct {
        t_in  beat;
        bit   typed;
        t_out reply;
    } t_row;

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    // mirror of the slot table
    bit                tbl_valid [SLOTS];
    bit [PID_BITS-1:0] tbl_pid   [SLOTS];
    bit                tbl_bound [SLOTS];
    bit [HANDLE_W-1:0] tbl_space [SLOTS];
    int                tbl_count    = 0;
    bit [PID_BITS-1:0] tbl_next_pid = '0;

    t_out expected_replies [$];
    t_row directed_rows [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int cycle_count    = 0;
    int mismatches     = 0;
    int beats_sent     = 0;
    int replies_checked = 0;
    int status_seen [8];

    process_slot_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run timed out after %0d cycles, %0d replies outstanding",
                 cycle_count, expected_replies.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_in make_beat(t_op op, logic [ID_W-1:0] id,
                                      logic [HANDLE_W-1:0] handle);
        t_in beat;
        beat.cmd          = op;
        beat.target_id    = id;
        beat.space_handle = handle;
        return beat;
    endfunction

    // apply one command to the mirror and return the reply it should produce
    function automatic t_out table_step(t_in beat);
        t_out reply;
        int   free_slot;
        int   hit_slot;
        int   i;
        free_slot = -1;
        hit_slot  = -1;
        // lowest free slot and lowest live slot holding the id
        for (i = SLOTS - 1; i >= 0; i--) begin
            if (!tbl_valid[i])
                free_slot = i;
            else if (CMP_W'(tbl_pid[i]) == CMP_W'(beat.target_id))
                hit_slot = i;
        end
        reply.status = ST_OK;
        reply.new_id = '0;
        case (beat.cmd)
            CMD_ACQUIRE: begin
                if (tbl_count >= SLOTS || free_slot < 0) begin
                    reply.status = ST_FULL;
                end else begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_pid[free_slot]   = tbl_next_pid;
                    tbl_bound[free_slot] = 1'b0;
                    tbl_space[free_slot] = '0;
                    reply.new_id = ID_W'(tbl_next_pid);
                    tbl_next_pid = tbl_next_pid + 1'b1;
                    tbl_count++;
                end
            end
            CMD_BIND: begin
                if (beat.space_handle == '0) begin
                    reply.status = ST_NULL;
                end else if (hit_slot < 0) begin
                    reply.status = ST_UNKNOWN;
                end else if (tbl_bound[hit_slot]) begin
                    reply.status = ST_BOUND;
                end else begin
                    tbl_space[hit_slot] = beat.space_handle;
                    tbl_bound[hit_slot] = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (hit_slot < 0) begin
                    reply.status = ST_UNKNOWN;
                end else begin
                    tbl_valid[hit_slot] = 1'b0;
                    tbl_bound[hit_slot] = 1'b0;
                    if (tbl_count > 0)
                        tbl_count--;
                end
            end
            default: begin
                // count query changes nothing
            end
        endcase
        reply.running_count = RCOUNT_W'(tbl_count);
        return reply;
    endfunction

    // random command, mostly aimed at live ids
    function automatic t_in random_beat();
        t_in              beat;
        int               roll;
        int               live;
        int               pick;
        int               i;
        logic [ID_W-1:0]  live_id;
        beat.target_id    = ID_W'($urandom);
        beat.space_handle = $urandom;
        live    = 0;
        live_id = '0;
        for (i = 0; i < SLOTS; i++)
            if (tbl_valid[i])
                live++;
        pick = (live > 0) ? $urandom_range(0, live - 1) : 0;
        for (i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i]) begin
                if (pick == 0)
                    live_id = ID_W'(tbl_pid[i]);
                pick--;
            end
        end
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            beat.cmd = CMD_ACQUIRE;
        end else if (roll < 60) begin
            beat.cmd = CMD_BIND;
            if (live > 0 && $urandom_range(0, 99) < 80)
                beat.target_id = live_id;
            // null and all-ones handles now and then
            case ($urandom_range(0, 9))
                0: beat.space_handle = '0;
                1: beat.space_handle = '1;
                default: ;
            endcase
        end else if (roll < 88) begin
            beat.cmd = CMD_RELEASE;
            if (live > 0 && $urandom_range(0, 99) < 85)
                beat.target_id = live_id;
        end else begin
            beat.cmd = CMD_COUNT;
        end
        return beat;
    endfunction

    // offer one beat, hold it until taken, then log what it should produce
    task automatic send_beat(t_in beat, bit typed, t_out typed_reply);
        t_out predicted;
        bit   taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        taken = 1'b0;
        while (!taken) begin
            @(posedge clk);
            taken = !in_stall;
        end
        predicted = table_step(beat);
        expected_replies.push_back(typed ? typed_reply : predicted);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic add_row(t_op op, logic [ID_W-1:0] id, logic [HANDLE_W-1:0] handle,
                           bit typed, t_status st, int nid, int cnt);
        t_row row;
        row.beat                = make_beat(op, id, handle);
        row.typed               = typed;
        row.reply.status        = st;
        row.reply.new_id        = ID_W'(nid);
        row.reply.running_count = RCOUNT_W'(cnt);
        directed_rows.push_back(row);
    endtask

    // receiver: random stalls, or a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // reply checker
    always @(posedge clk) begin : check_replies
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_replies.size() == 0) begin
                $error("reply beat with nothing expected: status %0d new_id %0d count %0d",
                       out_data.status, out_data.new_id, out_data.running_count);
                mismatches++;
            end else begin
                want = expected_replies.pop_front();
                if (out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    mismatches++;
                end
                if (out_data.new_id !== want.new_id) begin
                    $error("new_id: expected %0d, got %0d", want.new_id, out_data.new_id);
                    mismatches++;
                end
                if (out_data.running_count !== want.running_count) begin
                    $error("running_count: expected %0d, got %0d",
                           want.running_count, out_data.running_count);
                    mismatches++;
                end
                status_seen[want.status]++;
                replies_checked++;
            end
        end
    end

    // stimulus
    initial begin
        t_out            no_reply;
        int              k;
        int              p;
        no_reply = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows
        add_row(CMD_COUNT,   '0, '0, 1, ST_OK,      0, 0);
        add_row(CMD_RELEASE, '0, '0, 1, ST_UNKNOWN, 0, 0);   // empty slots are skipped
        add_row(CMD_BIND,    '0, '0, 1, ST_NULL,    0, 0);   // null handle before lookup
        add_row(CMD_BIND,    '1, '1, 1, ST_UNKNOWN, 0, 0);
        // fill the table, ignored fields flipping between all zeros and all ones
        for (k = 0; k < SLOTS; k++)
            add_row(CMD_ACQUIRE, {ID_W{k[0]}}, {HANDLE_W{k[0]}}, 1, ST_OK, k, k + 1);
        add_row(CMD_ACQUIRE, '0, '0, 1, ST_FULL, 0, SLOTS);  // full table
        add_row(CMD_BIND,    '0, '1, 0, ST_OK, 0, 0);
        add_row(CMD_BIND,    '0, HANDLE_W'(1), 0, ST_OK, 0, 0);  // rebind
        add_row(CMD_BIND,    ID_W'(3), '0, 1, ST_NULL, 0, SLOTS);
        add_row(CMD_RELEASE, ID_W'(5), '0, 0, ST_OK, 0, 0);
        add_row(CMD_ACQUIRE, '1, '1, 0, ST_OK, 0, 0);        // refills the hole
        add_row(CMD_COUNT,   '1, '1, 0, ST_OK, 0, 0);

        @(negedge clk);
        foreach (directed_rows[r])
            send_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].reply);

        // random traffic under several idle patterns
        for (p = 0; p < PH_COUNT; p++) begin
            case (t_phase'(p))
                PH_FREE: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                PH_SENDER_IDLE: begin
                    send_idle_pct  = 76;
                    recv_stall_pct = 0;
                end
                PH_RECEIVER_STALL: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 76;
                end
                PH_BOTH_IDLE: begin
                    send_idle_pct  = 19;
                    recv_stall_pct = 19;
                end
                default: begin
                    // long hold-off while the sender keeps pushing
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_request   = HOLD_CYCLES;
                end
            endcase
            repeat (RANDOM_PER_PHASE)
                send_beat(random_beat(), 1'b0, no_reply);
        end
        in_valid <= 1'b0;

        // drain
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands driven over five idle patterns, %0d replies checked",
                 beats_sent, replies_checked);
        $display("replies by status: ok %0d, full %0d, unknown %0d, bound %0d, null %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_UNKNOWN],
                 status_seen[ST_BOUND], status_seen[ST_NULL]);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pst_pkg.sv
src/pst_ctrl.sv
src/pst_dp.sv
src/process_slot_table.sv
sim/tb_process_slot_table.sv
